/* src/bgpup_pkg.sv */
`default_nettype none
package bgpup_pkg;

    localparam logic [3:0] PH_WLEN_HI   = 4'd0;
    localparam logic [3:0] PH_WLEN_LO   = 4'd1;
    localparam logic [3:0] PH_WITHDRAWN = 4'd2;
    localparam logic [3:0] PH_ALEN_HI   = 4'd3;
    localparam logic [3:0] PH_ALEN_LO   = 4'd4;
    localparam logic [3:0] PH_FLAGS     = 4'd5;
    localparam logic [3:0] PH_CODE      = 4'd6;
    localparam logic [3:0] PH_LEN_HI    = 4'd7;
    localparam logic [3:0] PH_LEN_LO    = 4'd8;
    localparam logic [3:0] PH_VALUE     = 4'd9;
    localparam logic [3:0] PH_NLRI      = 4'd10;
    localparam logic [3:0] PH_SKIP      = 4'd11;

    localparam logic [3:0] K_WITHDRAWN  = 4'd0;
    localparam logic [3:0] K_NLRI       = 4'd1;
    localparam logic [3:0] K_HEADER     = 4'd2;
    localparam logic [3:0] K_ORIGIN     = 4'd3;
    localparam logic [3:0] K_NEXTHOP    = 4'd4;
    localparam logic [3:0] K_MED        = 4'd5;
    localparam logic [3:0] K_LOCALPREF  = 4'd6;
    localparam logic [3:0] K_ASN        = 4'd7;
    localparam logic [3:0] K_COMMUNITY  = 4'd8;
    localparam logic [3:0] K_AGGR_ASN   = 4'd9;
    localparam logic [3:0] K_AGGR_ADDR  = 4'd10;
    localparam logic [3:0] K_ORIGINATOR = 4'd11;
    localparam logic [3:0] K_EOR        = 4'd12;
    localparam logic [3:0] K_ERROR      = 4'd13;
    localparam logic [3:0] K_DONE       = 4'd14;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_HEADER    = 3'd1;
    localparam logic [2:0] E_WITHDRAWN = 3'd2;
    localparam logic [2:0] E_SECTION   = 3'd3;
    localparam logic [2:0] E_VALUE     = 3'd4;
    localparam logic [2:0] E_WIDE      = 3'd5;

    localparam logic [7:0] AC_ORIGIN     = 8'd1;
    localparam logic [7:0] AC_AS_PATH    = 8'd2;
    localparam logic [7:0] AC_NEXTHOP    = 8'd3;
    localparam logic [7:0] AC_MED        = 8'd4;
    localparam logic [7:0] AC_LOCALPREF  = 8'd5;
    localparam logic [7:0] AC_AGGREGATOR = 8'd7;
    localparam logic [7:0] AC_COMMUNITY  = 8'd8;
    localparam logic [7:0] AC_ORIGINATOR = 8'd9;

    localparam logic [5:0] AP_TYPE  = 6'd63;
    localparam logic [5:0] AP_COUNT = 6'd62;
    localparam int REC_W = 86;

    typedef struct packed {
        logic        final_record;
        logic [2:0]  error_code;
        logic [7:0]  segment_kind;
        logic [15:0] attribute_length;
        logic [7:0]  attribute_code;
        logic [7:0]  attribute_flags;
        logic [31:0] value_word;
        logic [5:0]  prefix_length;
        logic [3:0]  record_kind;
    } rec_t;

endpackage
`default_nettype wire

/* src/bgp_update_stream_parser.sv */
`default_nettype none
// Parser for the body of a BGP UPDATE message, one byte per request.
// The slave channel carries tdata = byte_value and tuser = last_byte; the
// master channel carries one record per request, packed into tdata, with
// final_record in tlast. A byte yields zero, one or two records.
// The byte is decoded in the cycle it is accepted and its records are
// loaded into a two-entry output buffer, so the first record is visible on
// the master side in the cycle after acceptance. One byte is taken every
// cycle while the buffer has room; the buffer drains one record per cycle
// while m_axis_tready is high. When the receiver stalls, records wait in
// the buffer and s_axis_tready drops unless two new records could be stored.
// The AS number width register (1 selects four-octet AS_PATH numbers) is
// written with cfg_wr_en and cfg_wr_data.
// Reset clears the parse state and the register and empties the buffer; the
// last byte of every message returns the parse state to its reset values.
module bgp_update_stream_parser
    import bgpup_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // byte_value
    input  wire logic        s_axis_tuser,  // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // record_kind[3:0], prefix_length[9:4], value_word[41:10],
    // attribute_flags[49:42], attribute_code[57:50], attribute_length[73:58],
    // segment_kind[81:74], error_code[84:82], zero[87:85]
    output logic [87:0]      m_axis_tdata,
    output logic             m_axis_tlast   // final_record
);

    logic        asn4_reg;
    logic [3:0]  ph_reg, ph_next;
    logic [15:0] sec_reg, sec_next, wt_reg, wt_next, at_reg, at_next;
    logic [15:0] vr_reg, vr_next, cl_reg, cl_next;
    logic [7:0]  cf_reg, cf_next, cc_reg, cc_next, pb_reg, pb_next;
    logic [7:0]  sc_reg, sc_next, st_reg, st_next;
    logic [5:0]  fb_reg, fb_next;
    logic [31:0] wa_reg, wa_next;

    rec_t        buf_reg [2];
    rec_t        buf_next [2];
    logic [1:0]  cnt_reg, cnt_next;

    rec_t        r0, r1;
    logic [1:0]  n;
    logic        acc, pop;

    assign pop = m_axis_tvalid && m_axis_tready;
    // Room for two new records after this cycle's pop.
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready)
        || (cnt_reg == 2'd2 && 1'b0);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata = {3'b000, buf_reg[0][84:0]};
    assign m_axis_tlast = buf_reg[0].final_record;

    function automatic rec_t mk(input logic [3:0] k, input logic [5:0] pl,
                                input logic [31:0] v, input logic [2:0] e,
                                input logic at, input logic [7:0] f,
                                input logic [7:0] c, input logic [15:0] l,
                                input logic [7:0] s);
        rec_t r;
        r.record_kind = k;
        r.prefix_length = pl;
        r.value_word = v;
        r.attribute_flags = at ? f : 8'd0;
        r.attribute_code = at ? c : 8'd0;
        r.attribute_length = at ? l : 16'd0;
        r.segment_kind = (k == K_ASN) ? s : 8'd0;
        r.error_code = e;
        r.final_record = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  prior_ph;
        logic [3:0]  pkind;
        logic [5:0]  asz;
        logic [5:0]  tot;
        logic [1:0]  idx;
        logic [15:0] off;
        logic [5:0]  gsz;
        rec_t        rq [2];
        rec_t        t;
        b = s_axis_tdata;
        prior_ph = ph_reg;
        ph_next = ph_reg; sec_next = sec_reg; wt_next = wt_reg; at_next = at_reg;
        vr_next = vr_reg; cl_next = cl_reg; cf_next = cf_reg; cc_next = cc_reg;
        pb_next = pb_reg; sc_next = sc_reg; st_next = st_reg; fb_next = fb_reg;
        wa_next = wa_reg;
        n = 2'd0;
        rq[0] = '0; rq[1] = '0; t = '0;
        asz = asn4_reg ? 6'd4 : 6'd2;
        pkind = (ph_reg == PH_WITHDRAWN) ? K_WITHDRAWN : K_NLRI;
        off = cl_reg - vr_reg;
        tot = 6'((9'(pb_reg) + 9'd7) >> 3);
        idx = 2'(tot - fb_reg);
        gsz = (cl_reg == 16'd8) ? 6'd4 : ((cl_reg == 16'd6) ? 6'd2 : 6'd0);
        case (ph_reg)
            PH_WLEN_HI:
            begin
                wt_next = {b, 8'd0};
                ph_next = PH_WLEN_LO;
            end
            PH_WLEN_LO:
            begin
                wt_next = {wt_reg[15:8], b};
                sec_next = {wt_reg[15:8], b};
                fb_next = '0;
                ph_next = ({wt_reg[15:8], b} != 16'd0) ? PH_WITHDRAWN : PH_ALEN_HI;
            end
            PH_WITHDRAWN, PH_NLRI:
            begin
                if (fb_reg == 6'd0)
                begin
                    pb_next = b;
                    wa_next = '0;
                    fb_next = 6'((9'(b) + 9'd7) >> 3);
                    if (b > 8'd32)
                    begin
                        rq[n[0]] = mk(K_ERROR, 6'd0, {24'd0, b}, E_WIDE, 1'b0,
                                      cf_reg, cc_reg, cl_reg, st_reg);
                        n = n + 2'd1;
                    end
                    else if (b == 8'd0)
                    begin
                        rq[n[0]] = mk(pkind, 6'd0, 32'd0, E_NONE, 1'b0,
                                      cf_reg, cc_reg, cl_reg, st_reg);
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    if (pb_reg <= 8'd32)
                        wa_next = wa_reg | ({24'd0, b} << {~idx, 3'b000});
                    fb_next = fb_reg - 6'd1;
                    if (fb_reg == 6'd1 && pb_reg <= 8'd32)
                    begin
                        rq[n[0]] = mk(pkind, pb_reg[5:0], wa_next, E_NONE, 1'b0,
                                      cf_reg, cc_reg, cl_reg, st_reg);
                        n = n + 2'd1;
                    end
                end
                if (ph_reg == PH_WITHDRAWN)
                begin
                    if (sec_reg != 16'd0)
                        sec_next = sec_reg - 16'd1;
                    if (sec_next == 16'd0)
                    begin
                        if (fb_next != 6'd0 && pb_next <= 8'd32)
                        begin
                            rq[n[0]] = mk(K_ERROR, 6'd0, 32'd0, E_WITHDRAWN, 1'b0,
                                          cf_reg, cc_reg, cl_reg, st_reg);
                            n = n + 2'd1;
                        end
                        fb_next = '0;
                        ph_next = PH_ALEN_HI;
                    end
                end
            end
            PH_ALEN_HI:
            begin
                at_next = {b, 8'd0};
                ph_next = PH_ALEN_LO;
            end
            PH_ALEN_LO:
            begin
                at_next = {at_reg[15:8], b};
                sec_next = {at_reg[15:8], b};
                fb_next = '0;
                ph_next = ({at_reg[15:8], b} != 16'd0) ? PH_FLAGS : PH_NLRI;
            end
            PH_FLAGS:
            begin
                cf_next = b; cc_next = '0; cl_next = '0;
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                ph_next = PH_CODE;
            end
            PH_CODE:
            begin
                cc_next = b;
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                ph_next = cf_reg[4] ? PH_LEN_HI : PH_LEN_LO;
            end
            PH_LEN_HI:
            begin
                cl_next = {b, 8'd0};
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                ph_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                cl_next = {cl_reg[15:8], b};
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                if (cl_next > sec_next)
                begin
                    rq[0] = mk(K_ERROR, 6'd0, 32'd0, E_VALUE, 1'b1,
                               cf_reg, cc_reg, cl_next, st_reg);
                    n = 2'd1;
                    ph_next = (sec_next != 16'd0) ? PH_SKIP : PH_NLRI;
                end
                else
                begin
                    rq[0] = mk(K_HEADER, 6'd0, 32'd0, E_NONE, 1'b1,
                               cf_reg, cc_reg, cl_next, st_reg);
                    n = 2'd1;
                    wa_next = '0;
                    sc_next = '0;
                    fb_next = (cc_reg == AC_AS_PATH) ? AP_TYPE : 6'd0;
                    vr_next = cl_next;
                    if (cl_next != 16'd0)
                        ph_next = PH_VALUE;
                    else
                        ph_next = (sec_next != 16'd0) ? PH_FLAGS : PH_NLRI;
                end
            end
            PH_VALUE:
            begin
                case (cc_reg)
                    AC_ORIGIN:
                        if (off == 16'd0)
                        begin
                            rq[0] = mk(K_ORIGIN, 6'd0, {24'd0, b}, E_NONE, 1'b1,
                                       cf_reg, cc_reg, cl_reg, st_reg);
                            n = 2'd1;
                        end
                    AC_AS_PATH:
                        if (fb_reg == AP_TYPE)
                        begin
                            st_next = b;
                            fb_next = AP_COUNT;
                        end
                        else if (fb_reg == AP_COUNT)
                        begin
                            sc_next = b;
                            wa_next = '0;
                            fb_next = (b != 8'd0) ? asz : AP_TYPE;
                        end
                        else
                        begin
                            wa_next = {wa_reg[23:0], b};
                            if (fb_reg <= 6'd1)
                            begin
                                rq[0] = mk(K_ASN, 6'd0, wa_next, E_NONE, 1'b1,
                                           cf_reg, cc_reg, cl_reg, st_reg);
                                n = 2'd1;
                                wa_next = '0;
                                sc_next = (sc_reg != 8'd0) ? sc_reg - 8'd1 : 8'd0;
                                fb_next = (sc_next != 8'd0) ? asz : AP_TYPE;
                            end
                            else
                                fb_next = fb_reg - 6'd1;
                        end
                    AC_NEXTHOP, AC_MED, AC_LOCALPREF, AC_ORIGINATOR:
                        if (off < 16'd4)
                        begin
                            wa_next = {wa_reg[23:0], b};
                            if (off == 16'd3)
                            begin
                                case (cc_reg)
                                    AC_NEXTHOP:   t.record_kind = K_NEXTHOP;
                                    AC_MED:       t.record_kind = K_MED;
                                    AC_LOCALPREF: t.record_kind = K_LOCALPREF;
                                    default:      t.record_kind = K_ORIGINATOR;
                                endcase
                                rq[0] = mk(t.record_kind, 6'd0, wa_next, E_NONE,
                                           1'b1, cf_reg, cc_reg, cl_reg, st_reg);
                                n = 2'd1;
                            end
                        end
                    AC_AGGREGATOR:
                        if (gsz != 6'd0)
                        begin
                            wa_next = {wa_reg[23:0], b};
                            if (off == 16'(gsz - 6'd1))
                            begin
                                rq[0] = mk(K_AGGR_ASN, 6'd0, wa_next, E_NONE, 1'b1,
                                           cf_reg, cc_reg, cl_reg, st_reg);
                                n = 2'd1;
                                wa_next = '0;
                            end
                            else if (off == 16'(gsz + 6'd3))
                            begin
                                rq[0] = mk(K_AGGR_ADDR, 6'd0, wa_next, E_NONE, 1'b1,
                                           cf_reg, cc_reg, cl_reg, st_reg);
                                n = 2'd1;
                            end
                        end
                    AC_COMMUNITY:
                    begin
                        wa_next = {16'd0, wa_reg[7:0], b};
                        if (off[0])
                        begin
                            rq[0] = mk(K_COMMUNITY, 6'd0, wa_next, E_NONE, 1'b1,
                                       cf_reg, cc_reg, cl_reg, st_reg);
                            n = 2'd1;
                        end
                    end
                    default: ;
                endcase
                if (vr_reg != 16'd0) vr_next = vr_reg - 16'd1;
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                if (vr_next == 16'd0)
                begin
                    fb_next = '0;
                    ph_next = (sec_next != 16'd0) ? PH_FLAGS : PH_NLRI;
                end
            end
            PH_SKIP:
            begin
                if (sec_reg != 16'd0) sec_next = sec_reg - 16'd1;
                if (sec_next == 16'd0) ph_next = PH_NLRI;
            end
            default:
                ph_next = PH_WLEN_HI;
        endcase

        if ((prior_ph == PH_FLAGS || prior_ph == PH_CODE || prior_ph == PH_LEN_HI)
            && sec_next == 16'd0)
        begin
            rq[n[0]] = mk(K_ERROR, 6'd0, 32'd0, E_SECTION, 1'b0,
                          cf_reg, cc_reg, cl_reg, st_reg);
            n = n + 2'd1;
            fb_next = '0;
            ph_next = PH_NLRI;
        end

        if (s_axis_tuser)
        begin
            case (ph_next)
                PH_WLEN_HI, PH_WLEN_LO, PH_ALEN_HI, PH_ALEN_LO:
                    t = mk(K_ERROR, 6'd0, 32'd0, E_HEADER, 1'b0, cf_reg, cc_reg,
                           cl_reg, st_reg);
                PH_WITHDRAWN:
                    t = mk(K_ERROR, 6'd0, 32'd0, E_WITHDRAWN, 1'b0, cf_reg, cc_reg,
                           cl_reg, st_reg);
                PH_NLRI:
                    if (prior_ph == PH_ALEN_LO && wt_reg == 16'd0 && at_next == 16'd0)
                        t = mk(K_EOR, 6'd0, 32'd0, E_NONE, 1'b0, cf_reg, cc_reg,
                               cl_reg, st_reg);
                    else
                        t = mk(K_DONE, 6'd0, 32'd0, E_NONE, 1'b0, cf_reg, cc_reg,
                               cl_reg, st_reg);
                default:
                    t = mk(K_ERROR, 6'd0, 32'd0, E_SECTION, 1'b0, cf_reg, cc_reg,
                           cl_reg, st_reg);
            endcase
            if (n != 2'd2)
            begin
                t.final_record = 1'b1;
                rq[n[0]] = t;
                n = n + 2'd1;
            end
            else
                rq[1].final_record = 1'b1;
            ph_next = PH_WLEN_HI;
            sec_next = '0; wt_next = '0; at_next = '0; vr_next = '0;
            cf_next = '0; cc_next = '0; cl_next = '0; pb_next = '0;
            fb_next = '0; wa_next = '0; sc_next = '0; st_next = '0;
        end
        r0 = rq[0];
        r1 = rq[1];
    end

    always_comb
    begin
        logic [1:0] base;
        buf_next[0] = buf_reg[0];
        buf_next[1] = buf_reg[1];
        base = cnt_reg;
        if (pop)
        begin
            buf_next[0] = buf_reg[1];
            base = cnt_reg - 2'd1;
        end
        cnt_next = base;
        if (acc && n != 2'd0)
        begin
            if (base == 2'd0)
            begin
                buf_next[0] = r0;
                buf_next[1] = r1;
            end
            else
                buf_next[1] = r0;
            cnt_next = base + n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asn4_reg <= 1'b0;
            cnt_reg <= '0;
            ph_reg <= PH_WLEN_HI;
            sec_reg <= '0; wt_reg <= '0; at_reg <= '0; vr_reg <= '0;
            cf_reg <= '0; cc_reg <= '0; cl_reg <= '0; pb_reg <= '0;
            fb_reg <= '0; wa_reg <= '0; sc_reg <= '0; st_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                asn4_reg <= cfg_wr_data;
            cnt_reg <= cnt_next;
            if (acc)
            begin
                ph_reg <= ph_next;
                sec_reg <= sec_next; wt_reg <= wt_next; at_reg <= at_next;
                vr_reg <= vr_next; cf_reg <= cf_next; cc_reg <= cc_next;
                cl_reg <= cl_next; pb_reg <= pb_next; fb_reg <= fb_next;
                wa_reg <= wa_next; sc_reg <= sc_next; st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg[0] <= buf_next[0];
        buf_reg[1] <= buf_next[1];
    end

endmodule
`default_nettype wire

/* bench/testbench.sv */
module testbench
    import bgpup_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'd0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [87:0] m_data;
    logic        m_last;

    bgp_update_stream_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    always #6 clk = ~clk;

    logic [8:0] pending_bytes[$];
    rec_t       expected_records[$];
    logic [7:0] msg[$];
    logic [8:0] next_item;
    int tx_idle = 0;
    int rx_idle = 0;
    int cycles = 0;
    int hold_left = 0;
    logic hold_start = 1'b0;
    int mismatches = 0;
    int records_seen = 0;
    int bytes_sent = 0;
    int messages = 0;
    int bytes_queued = 0;

    // Predictor state.
    logic       asn4;
    logic [3:0] phase;
    logic [15:0] sec_left, wd_total, at_total, val_left, cur_len;
    logic [7:0] cur_flags, cur_code, pfx_bits, seg_left, seg_kind_held;
    logic [5:0] fld_left;
    logic [31:0] acc;
    int step_count;

    function automatic void clear_parse();
        phase = PH_WLEN_HI;
        sec_left = 0; wd_total = 0; at_total = 0; val_left = 0; cur_len = 0;
        cur_flags = 0; cur_code = 0; pfx_bits = 0; seg_left = 0; seg_kind_held = 0;
        fld_left = 0; acc = 0;
    endfunction

    function automatic void emit(logic [3:0] kind, logic [5:0] plen, logic [31:0] val,
                                 logic [2:0] err, logic with_attr);
        rec_t r;
        if (step_count >= 2)
            return;
        r = '0;
        r.record_kind = kind;
        r.prefix_length = plen;
        r.value_word = val;
        r.attribute_flags = with_attr ? cur_flags : 8'd0;
        r.attribute_code = with_attr ? cur_code : 8'd0;
        r.attribute_length = with_attr ? cur_len : 16'd0;
        r.segment_kind = (kind == K_ASN) ? seg_kind_held : 8'd0;
        r.error_code = err;
        expected_records.insert(expected_records.size(), r);
        step_count++;
    endfunction

    function automatic void prefix_in(logic [7:0] b, logic [3:0] kind);
        int total;
        int idx;
        if (fld_left == 0)
        begin
            pfx_bits = b;
            acc = 0;
            fld_left = 6'((int'(b) + 7) / 8);
            if (b > 32)
                emit(K_ERROR, 0, {24'd0, b}, E_WIDE, 1'b0);
            else if (b == 0)
                emit(kind, 0, 0, E_NONE, 1'b0);
        end
        else
        begin
            total = (int'(pfx_bits) + 7) / 8;
            if (pfx_bits <= 32)
            begin
                idx = (total - int'(fld_left)) & 3;
                acc = acc | (32'(b) << (8 * (3 - idx)));
            end
            fld_left = fld_left - 1;
            if (fld_left == 0 && pfx_bits <= 32)
                emit(kind, pfx_bits[5:0], acc, E_NONE, 1'b0);
        end
    endfunction

    function automatic void word_in(logic [7:0] b, logic [15:0] off, logic [3:0] kind);
        if (off < 4)
        begin
            acc = {acc[23:0], b};
            if (off == 3)
                emit(kind, 0, acc, E_NONE, 1'b1);
        end
    endfunction

    function automatic void as_path_in(logic [7:0] b);
        logic [5:0] asz;
        asz = asn4 ? 6'd4 : 6'd2;
        if (fld_left == AP_TYPE)
        begin
            seg_kind_held = b;
            fld_left = AP_COUNT;
        end
        else if (fld_left == AP_COUNT)
        begin
            seg_left = b;
            acc = 0;
            fld_left = (b != 0) ? asz : AP_TYPE;
        end
        else
        begin
            acc = {acc[23:0], b};
            if (fld_left > 0)
                fld_left = fld_left - 1;
            if (fld_left == 0)
            begin
                emit(K_ASN, 0, acc, E_NONE, 1'b1);
                acc = 0;
                if (seg_left > 0)
                    seg_left = seg_left - 1;
                fld_left = (seg_left != 0) ? asz : AP_TYPE;
            end
        end
    endfunction

    function automatic void value_in(logic [7:0] b, logic [15:0] off);
        int asz;
        case (cur_code)
            AC_ORIGIN: if (off == 0) emit(K_ORIGIN, 0, {24'd0, b}, E_NONE, 1'b1);
            AC_AS_PATH: as_path_in(b);
            AC_NEXTHOP: word_in(b, off, K_NEXTHOP);
            AC_MED: word_in(b, off, K_MED);
            AC_LOCALPREF: word_in(b, off, K_LOCALPREF);
            AC_AGGREGATOR:
            begin
                asz = (cur_len == 8) ? 4 : ((cur_len == 6) ? 2 : 0);
                if (asz != 0)
                begin
                    acc = {acc[23:0], b};
                    if (off == asz - 1)
                    begin
                        emit(K_AGGR_ASN, 0, acc, E_NONE, 1'b1);
                        acc = 0;
                    end
                    else if (off == asz + 3)
                        emit(K_AGGR_ADDR, 0, acc, E_NONE, 1'b1);
                end
            end
            AC_COMMUNITY:
            begin
                acc = {16'd0, acc[7:0], b};
                if (off[0])
                    emit(K_COMMUNITY, 0, acc, E_NONE, 1'b1);
            end
            AC_ORIGINATOR: word_in(b, off, K_ORIGINATOR);
            default: ;
        endcase
    endfunction

    function automatic void sec_step();
        if (sec_left > 0)
            sec_left = sec_left - 1;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        logic [3:0] prior;
        prior = phase;
        step_count = 0;
        case (phase)
            PH_WLEN_HI:
            begin
                wd_total = {b, 8'd0};
                phase = PH_WLEN_LO;
            end
            PH_WLEN_LO:
            begin
                wd_total = wd_total | 16'(b);
                sec_left = wd_total;
                fld_left = 0;
                phase = (wd_total != 0) ? PH_WITHDRAWN : PH_ALEN_HI;
            end
            PH_WITHDRAWN:
            begin
                prefix_in(b, K_WITHDRAWN);
                if (sec_left > 0)
                    sec_left = sec_left - 1;
                if (sec_left == 0)
                begin
                    if (fld_left != 0 && pfx_bits <= 32)
                        emit(K_ERROR, 0, 0, E_WITHDRAWN, 1'b0);
                    fld_left = 0;
                    phase = PH_ALEN_HI;
                end
            end
            PH_ALEN_HI:
            begin
                at_total = {b, 8'd0};
                phase = PH_ALEN_LO;
            end
            PH_ALEN_LO:
            begin
                at_total = at_total | 16'(b);
                sec_left = at_total;
                fld_left = 0;
                phase = (at_total != 0) ? PH_FLAGS : PH_NLRI;
            end
            PH_FLAGS:
            begin
                cur_flags = b;
                cur_code = 0;
                cur_len = 0;
                sec_step();
                phase = PH_CODE;
            end
            PH_CODE:
            begin
                cur_code = b;
                sec_step();
                phase = cur_flags[4] ? PH_LEN_HI : PH_LEN_LO;
            end
            PH_LEN_HI:
            begin
                cur_len = {b, 8'd0};
                sec_step();
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                cur_len = cur_len | 16'(b);
                sec_step();
                if (cur_len > sec_left)
                begin
                    emit(K_ERROR, 0, 0, E_VALUE, 1'b1);
                    phase = (sec_left != 0) ? PH_SKIP : PH_NLRI;
                end
                else
                begin
                    emit(K_HEADER, 0, 0, E_NONE, 1'b1);
                    acc = 0;
                    seg_left = 0;
                    fld_left = (cur_code == AC_AS_PATH) ? AP_TYPE : 6'd0;
                    val_left = cur_len;
                    if (cur_len != 0)
                        phase = PH_VALUE;
                    else
                        phase = (sec_left != 0) ? PH_FLAGS : PH_NLRI;
                end
            end
            PH_VALUE:
            begin
                value_in(b, cur_len - val_left);
                if (val_left > 0)
                    val_left = val_left - 1;
                sec_step();
                if (val_left == 0)
                begin
                    fld_left = 0;
                    phase = (sec_left != 0) ? PH_FLAGS : PH_NLRI;
                end
            end
            PH_SKIP:
            begin
                sec_step();
                if (sec_left == 0)
                    phase = PH_NLRI;
            end
            PH_NLRI: prefix_in(b, K_NLRI);
            default: phase = PH_WLEN_HI;
        endcase

        if ((prior == PH_FLAGS || prior == PH_CODE || prior == PH_LEN_HI) && sec_left == 0)
        begin
            emit(K_ERROR, 0, 0, E_SECTION, 1'b0);
            fld_left = 0;
            phase = PH_NLRI;
        end

        if (last)
        begin
            case (phase)
                PH_WLEN_HI, PH_WLEN_LO, PH_ALEN_HI, PH_ALEN_LO:
                    emit(K_ERROR, 0, 0, E_HEADER, 1'b0);
                PH_WITHDRAWN: emit(K_ERROR, 0, 0, E_WITHDRAWN, 1'b0);
                PH_NLRI:
                begin
                    if (prior == PH_ALEN_LO && wd_total == 0 && at_total == 0)
                        emit(K_EOR, 0, 0, E_NONE, 1'b0);
                    else
                        emit(K_DONE, 0, 0, E_NONE, 1'b0);
                end
                default: emit(K_ERROR, 0, 0, E_SECTION, 1'b0);
            endcase
            if (step_count > 0)
                expected_records[$].final_record = 1'b1;
            clear_parse();
        end
    endfunction

    // Sender: offers queued bytes and predicts the records of each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_valid && s_ready)
            begin
                parse_byte(s_data, s_last);
                bytes_sent++;
            end
            if (!s_valid || s_ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle)
                begin
                    next_item = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_data <= next_item[7:0];
                    s_last <= next_item[8];
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks every accepted record against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                records_seen++;
                if (expected_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected record: tdata %h tlast %b", m_data, m_last);
                end
                else if (rec_t'({m_last, m_data[84:0]}) != expected_records[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Record mismatch: expected %p, got %p",
                                 expected_records[0], rec_t'({m_last, m_data[84:0]}));
                    void'(expected_records.pop_front());
                end
                else
                begin
                    void'(expected_records.pop_front());
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_msg();
        for (int i = 0; i < msg.size(); i++)
            pending_bytes.insert(pending_bytes.size(),
                                 {(i == msg.size() - 1) ? 1'b1 : 1'b0, msg[i]});
        bytes_queued += msg.size();
        messages++;
        msg.delete();
    endtask

    task automatic add_prefix();
        int len;
        len = ($urandom_range(99) < 5) ? $urandom_range(255, 33) : $urandom_range(32, 0);
        msg.insert(msg.size(), 8'(len));
        for (int i = 0; i < (len + 7) / 8; i++)
            msg.insert(msg.size(), 8'($urandom));
    endtask

    task automatic fill_len(int pos, int len);
        msg[pos] = 8'(len >> 8);
        msg[pos + 1] = 8'(len);
    endtask

    task automatic add_attribute();
        logic [7:0] flags;
        logic [7:0] code;
        int pos;
        int start;
        int asz;
        int n;
        logic [7:0] codes[9];
        codes = '{AC_ORIGIN, AC_AS_PATH, AC_NEXTHOP, AC_MED, AC_LOCALPREF,
                  AC_AGGREGATOR, AC_COMMUNITY, AC_ORIGINATOR, 8'd0};
        flags = 8'($urandom);
        code = codes[$urandom_range(8)];
        if (code == 0)
            code = 8'($urandom);
        msg.insert(msg.size(), flags);
        msg.insert(msg.size(), code);
        pos = msg.size();
        msg.insert(msg.size(), 8'd0);
        if (flags[4])
            msg.insert(msg.size(), 8'd0);
        start = msg.size();
        asz = asn4 ? 4 : 2;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(9);
            for (int i = 0; i < n; i++)
                msg.insert(msg.size(), 8'($urandom));
        end
        else
        begin
            case (code)
                AC_ORIGIN: msg.insert(msg.size(), 8'($urandom_range(2)));
                AC_AS_PATH:
                    for (int s = $urandom_range(2, 1); s > 0; s--)
                    begin
                        msg.insert(msg.size(), 8'($urandom_range(2, 1)));
                        n = $urandom_range(3);
                        msg.insert(msg.size(), 8'(n));
                        for (int i = 0; i < n * asz; i++)
                            msg.insert(msg.size(), 8'($urandom));
                    end
                AC_NEXTHOP, AC_MED, AC_LOCALPREF, AC_ORIGINATOR:
                    for (int i = 0; i < 4; i++)
                        msg.insert(msg.size(), 8'($urandom));
                AC_AGGREGATOR:
                    for (int i = 0; i < ($urandom_range(1) ? 8 : 6); i++)
                        msg.insert(msg.size(), 8'($urandom));
                AC_COMMUNITY:
                    for (int i = 0; i < 4 * $urandom_range(3); i++)
                        msg.insert(msg.size(), 8'($urandom));
                default:
                    for (int i = 0; i < $urandom_range(5); i++)
                        msg.insert(msg.size(), 8'($urandom));
            endcase
        end
        n = msg.size() - start;
        if (flags[4])
            fill_len(pos, n);
        else
            msg[pos] = 8'(n);
    endtask

    task automatic add_update();
        int pos;
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            repeat (4) msg.insert(msg.size(), 8'd0);
        end
        else if (r < 10)
        begin
            repeat ($urandom_range(20, 1)) msg.insert(msg.size(), 8'($urandom));
        end
        else
        begin
            pos = msg.size();
            msg.insert(msg.size(), 8'd0);
            msg.insert(msg.size(), 8'd0);
            repeat ($urandom_range(3)) add_prefix();
            fill_len(pos, msg.size() - pos - 2);
            pos = msg.size();
            msg.insert(msg.size(), 8'd0);
            msg.insert(msg.size(), 8'd0);
            repeat ($urandom_range(4)) add_attribute();
            fill_len(pos, msg.size() - pos - 2);
            repeat ($urandom_range(3)) add_prefix();
            r = $urandom_range(99);
            if (r < 10)
                msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
            else if (r < 18)
                while (msg.size() > 1 && $urandom_range(3) != 0)
                    void'(msg.pop_back());
        end
        push_msg();
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || s_valid || expected_records.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_asn_mode(logic v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        asn4 = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int tx, int rx, logic mode, logic pressure);
        int target;
        wait_idle();
        write_asn_mode(mode);
        tx_idle = tx;
        rx_idle = rx;
        if (pressure)
        begin
            @(posedge clk);
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
        end
        target = bytes_queued + 500;
        while (bytes_queued < target)
            add_update();
    endtask

    initial
    begin
        asn4 = 1'b0;
        clear_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End-of-RIB, a one-byte message, a withdrawn prefix cut by the section
        // end, and an NLRI prefix wider than 32 bits.
        msg = '{8'h00, 8'h00, 8'h00, 8'h00};
        push_msg();
        msg = '{8'hff};
        push_msg();
        msg = '{8'h00, 8'h02, 8'h10, 8'h0a, 8'h00, 8'h00};
        push_msg();
        msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h28, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        push_msg();

        run_phase(28, 88, 1'b0, 1'b0);
        run_phase(88, 28, 1'b1, 1'b0);
        run_phase(0, 0, 1'b0, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Parsed %0d UPDATE bodies (%0d bytes) in both AS number widths;",
                 messages, bytes_sent);
        $display("%0d records checked, %0d mismatches.", records_seen, mismatches);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
src/bgpup_pkg.sv
src/bgp_update_stream_parser.sv
bench/testbench.sv
